FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/blg_pkg.sv
// Shared types, constants and the voltage table of the battery level gauge.
// No dependencies.
package blg_pkg;

  localparam int TABLE_ENTRIES_DEF = 101;
  localparam int AVG_SAMPLES_DEF   = 16;

  localparam int ROM_LEN   = 101;
  localparam int SAMPLE_W  = 12;
  localparam int LEVEL_W   = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 8;
  localparam int TDATA_W   = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_MAX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 3'd6;

  typedef struct packed {
    logic [LEVEL_W-1:0] clamp_max;
    logic [7:0]         window_len;
    logic [7:0]         up_threshold;
    logic [7:0]         down_threshold;
    logic [7:0]         slow_delay;
    logic [7:0]         fast_delay;
    logic [LEVEL_W-1:0] low_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    clamp_max:      7'd100,
    window_len:     8'd15,
    up_threshold:   8'd10,
    down_threshold: 8'd10,
    slow_delay:     8'd100,
    fast_delay:     8'd40,
    low_level:      7'd10
  };

  typedef struct packed {
    logic work_on;
    logic charge_full;
    logic charging;
  } flags_t;

  // packed so that level_percent sits in the low bits of tdata
  typedef struct packed {
    logic               shutdown_request;
    logic               average_done;
    logic [LEVEL_W-1:0] level_percent;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  // ADC codes for 100 % down to 0 %, ascending
  localparam logic [SAMPLE_W-1:0] VOLT_ROM [ROM_LEN] = '{
    12'd1499, 12'd1505, 12'd1511, 12'd1517, 12'd1523, 12'd1530, 12'd1536, 12'd1542,
    12'd1548, 12'd1554, 12'd1561, 12'd1567, 12'd1573, 12'd1579, 12'd1585, 12'd1592,
    12'd1598, 12'd1604, 12'd1610, 12'd1616, 12'd1623, 12'd1629, 12'd1635, 12'd1641,
    12'd1647, 12'd1654, 12'd1660, 12'd1666, 12'd1672, 12'd1678, 12'd1685, 12'd1691,
    12'd1697, 12'd1703, 12'd1709, 12'd1716, 12'd1722, 12'd1728, 12'd1734, 12'd1740,
    12'd1747, 12'd1753, 12'd1759, 12'd1765, 12'd1771, 12'd1778, 12'd1784, 12'd1790,
    12'd1796, 12'd1802, 12'd1809, 12'd1815, 12'd1821, 12'd1827, 12'd1833, 12'd1840,
    12'd1846, 12'd1852, 12'd1858, 12'd1864, 12'd1871, 12'd1877, 12'd1883, 12'd1889,
    12'd1895, 12'd1902, 12'd1908, 12'd1914, 12'd1920, 12'd1926, 12'd1933, 12'd1939,
    12'd1945, 12'd1951, 12'd1957, 12'd1964, 12'd1970, 12'd1976, 12'd1982, 12'd1988,
    12'd1995, 12'd2001, 12'd2007, 12'd2013, 12'd2019, 12'd2026, 12'd2032, 12'd2038,
    12'd2044, 12'd2050, 12'd2057, 12'd2063, 12'd2069, 12'd2075, 12'd2081, 12'd2088,
    12'd2094, 12'd2100, 12'd2106, 12'd2115, 12'd2119
  };

endpackage

FILE: rtl/blg_lookup.sv
// Table search of one sample and the running percent sum.
// Depends on blg_pkg.
module blg_lookup import blg_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF,
  parameter int SUM_W         = $clog2((TABLE_ENTRIES - 1) * AVG_SAMPLES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] sample,
  input  flags_t              flags_in,
  output logic [SUM_W-1:0]    total,
  output logic                done,
  output flags_t              flags
);

  localparam int PCT_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(AVG_SAMPLES);
  localparam int LOOK_N = (TABLE_ENTRIES < ROM_LEN) ? TABLE_ENTRIES : ROM_LEN;

  logic [SUM_W-1:0] percent_sum;
  logic [CNT_W-1:0] sample_count;
  logic [PCT_W-1:0] idx;
  logic [PCT_W-1:0] pct;
  logic [SUM_W-1:0] total_next;
  logic             done_next;

  // largest entry at or below the sample wins; entries are ascending
  always_comb begin
    idx = '0;
    for (int i = 1; i < LOOK_N; i++) begin
      if (VOLT_ROM[i] <= sample) idx = PCT_W'(i);
    end
  end

  assign pct        = PCT_W'(TABLE_ENTRIES - 1) - idx;
  assign total_next = percent_sum + SUM_W'(pct);
  assign done_next  = (sample_count == CNT_W'(AVG_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      percent_sum  <= '0;
      sample_count <= '0;
    end else if (en) begin
      percent_sum  <= done_next ? '0 : total_next;
      sample_count <= done_next ? '0 : sample_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total <= total_next;
      done  <= done_next;
      flags <= flags_in;
    end
  end

endmodule

FILE: rtl/blg_average.sv
// Rounded average of one percent sum and the upper clamp.
// Depends on blg_pkg.
module blg_average import blg_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF,
  parameter int SUM_W         = $clog2((TABLE_ENTRIES - 1) * AVG_SAMPLES + 1)
) (
  input  logic               clk,
  input  logic               en,
  input  logic [SUM_W-1:0]   total,
  input  logic               done_in,
  input  flags_t             flags_in,
  input  logic [LEVEL_W-1:0] clamp_max,
  output logic [LEVEL_W-1:0] avg,
  output logic               done,
  output flags_t             flags
);

  localparam int PCT_W = $clog2(TABLE_ENTRIES);
  localparam int X_W   = $clog2((TABLE_ENTRIES - 1) * AVG_SAMPLES + AVG_SAMPLES / 2 + 1);
  localparam int SH    = X_W + $clog2(AVG_SAMPLES);
  localparam int M_W   = X_W + 2;
  localparam int P_W   = X_W + M_W;
  // reciprocal rounded up; exact quotient for every x below 2**X_W
  localparam longint MULT = ((64'd1 << SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;

  logic [X_W-1:0]   x;
  logic [P_W-1:0]   prod;
  logic [PCT_W-1:0] quot;
  logic [LEVEL_W-1:0] avg_next;

  assign x    = X_W'(total) + X_W'(AVG_SAMPLES / 2);
  assign prod = P_W'(x) * P_W'(M_W'(MULT));
  assign quot = prod[SH +: PCT_W];

  always_comb begin
    if (9'(quot) > 9'(clamp_max)) avg_next = clamp_max;
    else                          avg_next = LEVEL_W'(quot);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      avg   <= avg_next;
      done  <= done_in;
      flags <= flags_in;
    end
  end

endmodule

FILE: rtl/blg_level.sv
// Reference tracking over a window and delayed stepping of the shown level.
// Depends on blg_pkg.
module blg_level import blg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [LEVEL_W-1:0] avg,
  input  logic               done_in,
  input  flags_t             flags,
  input  cfg_t               cfg,
  output result_t            result
);

  logic               first_average, first_average_next;
  logic [LEVEL_W-1:0] reference_level, reference_level_next;
  logic [LEVEL_W-1:0] shown_level, shown_level_next;
  logic [7:0]         window_count, window_count_next;
  logic [7:0]         rise_count, rise_count_next;
  logic [7:0]         fall_count, fall_count_next;
  logic [7:0]         charge_timer, charge_timer_next;
  logic [7:0]         discharge_timer, discharge_timer_next;
  logic               shut;

  always_comb begin
    logic [7:0] wc_inc;
    logic [7:0] delay;
    logic [7:0] tick;
    first_average_next   = first_average;
    reference_level_next = reference_level;
    shown_level_next     = shown_level;
    window_count_next    = window_count;
    rise_count_next      = rise_count;
    fall_count_next      = fall_count;
    charge_timer_next    = charge_timer;
    discharge_timer_next = discharge_timer;
    shut                 = 1'b0;
    wc_inc               = window_count + 8'd1;
    delay                = cfg.slow_delay;
    tick                 = '0;
    if (done_in) begin
      if (first_average) begin
        first_average_next   = 1'b0;
        reference_level_next = avg;
        shown_level_next     = avg;
      end else if (flags.charging || flags.work_on) begin
        if (wc_inc <= cfg.window_len) begin
          window_count_next = wc_inc;
          if (avg > reference_level)      rise_count_next = rise_count + 8'd1;
          else if (avg < reference_level) fall_count_next = fall_count + 8'd1;
        end else begin
          if (rise_count > cfg.up_threshold && flags.charging) begin
            reference_level_next = avg;
          end else if (fall_count > cfg.down_threshold && !flags.charging &&
                       flags.work_on) begin
            reference_level_next = avg;
          end
          window_count_next = '0;
          rise_count_next   = '0;
          fall_count_next   = '0;
        end

        if (!flags.charging && reference_level_next < cfg.low_level) begin
          delay = cfg.fast_delay;
        end

        // a timer never holds 255 here, so the increment cannot wrap
        if (flags.charging) begin
          discharge_timer_next = '0;
          if (flags.charge_full || reference_level_next > shown_level) begin
            tick = charge_timer + 8'd1;
            if (tick >= delay) begin
              charge_timer_next = '0;
              if (shown_level < LEVEL_MAX) shown_level_next = shown_level + 7'd1;
            end else begin
              charge_timer_next = tick;
            end
          end
        end else begin
          charge_timer_next = '0;
          if (reference_level_next < shown_level) begin
            tick = discharge_timer + 8'd1;
            if (tick >= delay) begin
              discharge_timer_next = '0;
              if (shown_level != '0) shown_level_next = shown_level - 7'd1;
            end else begin
              discharge_timer_next = tick;
            end
          end
        end

        // empty battery while running on it
        if (flags.work_on && !flags.charging && reference_level_next == '0) begin
          shown_level_next = '0;
          shut             = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_average   <= 1'b1;
      reference_level <= '0;
      shown_level     <= '0;
      window_count    <= '0;
      rise_count      <= '0;
      fall_count      <= '0;
      charge_timer    <= '0;
      discharge_timer <= '0;
    end else if (en) begin
      first_average   <= first_average_next;
      reference_level <= reference_level_next;
      shown_level     <= shown_level_next;
      window_count    <= window_count_next;
      rise_count      <= rise_count_next;
      fall_count      <= fall_count_next;
      charge_timer    <= charge_timer_next;
      discharge_timer <= discharge_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.level_percent    <= shown_level_next;
      result.average_done     <= done_in;
      result.shutdown_request <= shut;
    end
  end

endmodule

FILE: rtl/battery_level_gauge.sv
// Battery level gauge: input register, lookup/accumulate, average and level stages
// each hold one item and move whenever the stage after them has room; throughput is
// one item per cycle while m_tready is held high, and each item yields one result item.
// Synchronous active-high rst clears valids, counters, timers and config registers
// to their defaults; the first completed average then seeds the reference.
module battery_level_gauge import blg_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int AVG_SAMPLES   = AVG_SAMPLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [11:0] adc_sample, [12] charging, [13] charge_full, [14] work_on, [15] zero
  input  logic [TDATA_W-1:0]   s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [6:0] level_percent, [7] average_done, [8] shutdown_request, [15:9] zero
  output logic [TDATA_W-1:0]   m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int SUM_W = $clog2((TABLE_ENTRIES - 1) * AVG_SAMPLES + 1);

  cfg_t cfg;

  logic v0, v1, v2, vo;
  logic rdy_o, rdy2, rdy1;
  logic adv0, adv1, adv2;

  logic [SAMPLE_W-1:0] sample0;
  flags_t              flags0, flags1, flags2;
  logic [SUM_W-1:0]    total1;
  logic                done1, done2;
  logic [LEVEL_W-1:0]  avg2;
  result_t             result;

  // registers change only while no item still has to read them
  assign cfg_ready = !rst && !v0 && !v1 && !v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLAMP_MAX:      cfg.clamp_max      <= cfg_data[LEVEL_W-1:0];
        REG_WINDOW_LEN:     cfg.window_len     <= cfg_data;
        REG_UP_THRESHOLD:   cfg.up_threshold   <= cfg_data;
        REG_DOWN_THRESHOLD: cfg.down_threshold <= cfg_data;
        REG_SLOW_DELAY:     cfg.slow_delay     <= cfg_data;
        REG_FAST_DELAY:     cfg.fast_delay     <= cfg_data;
        REG_LOW_LEVEL:      cfg.low_level      <= cfg_data[LEVEL_W-1:0];
        default:            ;
      endcase
    end
  end

  // each stage fills when the next one has room or is moving on
  assign rdy_o    = !vo || m_tready;
  assign adv2     = v2 && rdy_o;
  assign rdy2     = !v2 || rdy_o;
  assign adv1     = v1 && rdy2;
  assign rdy1     = !v1 || rdy2;
  assign adv0     = v0 && rdy1;
  assign s_tready = !rst && (!v0 || rdy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
    end else begin
      v0 <= (v0 && !adv0) || (s_tvalid && s_tready);
      v1 <= (v1 && !adv1) || adv0;
      v2 <= (v2 && !adv2) || adv1;
      vo <= (vo && !m_tready) || adv2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample0             <= s_tdata[SAMPLE_W-1:0];
      flags0.charging     <= s_tdata[SAMPLE_W];
      flags0.charge_full  <= s_tdata[SAMPLE_W+1];
      flags0.work_on      <= s_tdata[SAMPLE_W+2];
    end
  end

  blg_lookup #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AVG_SAMPLES  (AVG_SAMPLES),
    .SUM_W        (SUM_W)
  ) u_lookup (
    .clk     (clk),
    .rst     (rst),
    .en      (adv0),
    .sample  (sample0),
    .flags_in(flags0),
    .total   (total1),
    .done    (done1),
    .flags   (flags1)
  );

  blg_average #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AVG_SAMPLES  (AVG_SAMPLES),
    .SUM_W        (SUM_W)
  ) u_average (
    .clk      (clk),
    .en       (adv1),
    .total    (total1),
    .done_in  (done1),
    .flags_in (flags1),
    .clamp_max(cfg.clamp_max),
    .avg      (avg2),
    .done     (done2),
    .flags    (flags2)
  );

  blg_level u_level (
    .clk    (clk),
    .rst    (rst),
    .en     (adv2),
    .avg    (avg2),
    .done_in(done2),
    .flags  (flags2),
    .cfg    (cfg),
    .result (result)
  );

  assign m_tvalid = vo;
  assign m_tdata  = {(TDATA_W - RESULT_W)'(0), result};

endmodule

FILE: rtl/blg_checker.sv
// Port-level checks on the gauge's result stream, bound to the top level.
// Depends on blg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module blg_checker import blg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  logic [LEVEL_W-1:0] level;
  logic               done;
  logic               shut;

  assign level = m_tdata[LEVEL_W-1:0];
  assign done  = m_tdata[LEVEL_W];
  assign shut  = m_tdata[LEVEL_W+1];

  // shutdown is only raised by a completed average
  `ASSERT_NOW(a_shut_needs_done, clk, rst, m_tvalid && shut, done)
  // an empty-battery item always shows level zero
  `ASSERT_NOW(a_shut_level_zero, clk, rst, m_tvalid && shut, level == '0)
  // pipeline is empty right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)
  `ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind battery_level_gauge blg_checker u_blg_checker (.*);
